@@ hdl/anp_pkg.sv @@
// ----------------------------------------------------------------------------
// anp_pkg
// Types, character codes and helpers shared by the ASCII number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anp_pkg;

   localparam int CharW  = 8;
   localparam int ValueW = 32;
   localparam int PosW   = 4;
   localparam int DigitW = 4;

   localparam logic [CharW-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CharW-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CharW-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CharW-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CharW-1:0] CHAR_UPPER_K = 8'h4B;
   localparam logic [CharW-1:0] CHAR_UPPER_M = 8'h4D;
   localparam logic [CharW-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CharW-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CharW-1:0] CHAR_LOWER_K = 8'h6B;
   localparam logic [CharW-1:0] CHAR_LOWER_M = 8'h6D;
   localparam logic [CharW-1:0] CHAR_LOWER_X = 8'h78;

   localparam int KILO_SHIFT = 10;
   localparam int MEGA_SHIFT = 20;

   // one result leaving the parse stage
   typedef struct packed {
      logic              valid;
      logic              ok;
      logic [ValueW-1:0] value;
   } result_type;

   typedef struct packed {
      logic              valid;
      logic [DigitW-1:0] digit;
   } digit_type;

   function automatic digit_type hex_digit(input logic [CharW-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.digit = '0;
      case (c) inside
         [CHAR_ZERO:CHAR_NINE]:       d.digit = DigitW'(c - CHAR_ZERO);
         [CHAR_LOWER_A:CHAR_LOWER_F]: d.digit = DigitW'(c - CHAR_LOWER_A + 8'd10);
         [CHAR_UPPER_A:CHAR_UPPER_F]: d.digit = DigitW'(c - CHAR_UPPER_A + 8'd10);
         default:                     d.valid = 1'b0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ascii_number_parser.sv @@
// Path: a character is held in the input register; its result, if any, is
//   registered in the output register and presented on rsp_ from there.
// Throughput: one character per cycle unless a result waits unaccepted.
// The input register refills while a result waits in the output register.
// Reset (synchronous, active high) empties both registers and returns the
//   parser to decimal mode at position zero with a cleared accumulator.
// ----------------------------------------------------------------------------
// ascii_number_parser
// Streams ASCII characters, one per transaction, into 32-bit unsigned values.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_number_parser #(
   parameter int SCAN_LIMIT = 11
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [anp_pkg::CharW-1:0]   req_tdata,   // [7:0] char_code
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [anp_pkg::ValueW-1:0]       rsp_tdata,   // [31:0] number_value
   output logic                             rsp_tuser    // [0] parse_ok
);
   import anp_pkg::*;

   logic             in_vld_ff, in_vld_in;
   logic [CharW-1:0] in_char_ff, in_char_in;
   logic             out_vld_ff, out_vld_in;
   logic [ValueW-1:0] out_value_ff, out_value_in;
   logic             out_ok_ff, out_ok_in;
   logic             advance;
   result_type       result;

   anp_core #(
      .SCAN_LIMIT (SCAN_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .char_code (in_char_ff),
      .result    (result)
   );

   always_comb begin
      advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
      req_tready = !in_vld_ff || advance;

      in_vld_in  = in_vld_ff;
      in_char_in = in_char_ff;
      if (req_tready) begin
         in_vld_in  = req_tvalid;
         in_char_in = req_tdata;
      end

      out_vld_in   = out_vld_ff;
      out_value_in = out_value_ff;
      out_ok_in    = out_ok_ff;
      if (advance) begin
         out_vld_in   = result.valid;
         out_value_in = result.value;
         out_ok_in    = result.ok;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      out_value_ff <= out_value_in;
      out_ok_ff    <= out_ok_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_ok_ff;

endmodule

`default_nettype wire

@@ hdl/anp_core.sv @@
// ----------------------------------------------------------------------------
// anp_core
// Parse state and the per-character step: accumulator, position, hex mode
// and skip flag, updated once for each character presented with step_en.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_core #(
   parameter int SCAN_LIMIT = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step_en,
   input  wire logic [anp_pkg::CharW-1:0]  char_code,
   output anp_pkg::result_type             result
);
   import anp_pkg::*;

   localparam logic [PosW-1:0] PosLimit = PosW'(SCAN_LIMIT);

   logic [ValueW-1:0] acc_ff, acc_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic              hex_ff, hex_in;
   logic              skip_ff, skip_in;

   digit_type         hex_d;
   logic [PosW-1:0]   pos_inc;
   logic              is_dec, is_kilo, is_mega, is_x;

   always_comb begin
      hex_d   = hex_digit(char_code);
      pos_inc = pos_ff + 1'b1;
      is_dec  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_kilo = (char_code == CHAR_LOWER_K) || (char_code == CHAR_UPPER_K);
      is_mega = (char_code == CHAR_LOWER_M) || (char_code == CHAR_UPPER_M);
      is_x    = (char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X);

      acc_in  = acc_ff;
      pos_in  = pos_ff;
      hex_in  = hex_ff;
      skip_in = skip_ff;
      result  = '0;

      if (step_en) begin
         if (skip_ff) begin
            if (char_code == CHAR_NUL) begin
               skip_in = 1'b0;
            end
         end else if (char_code == CHAR_NUL) begin
            result = '{valid: 1'b1, ok: 1'b1, value: acc_ff};
            acc_in = '0;
            pos_in = '0;
            hex_in = 1'b0;
         end else if (hex_ff) begin
            if ((pos_ff >= PosLimit) || !hex_d.valid) begin
               result  = '{valid: 1'b1, ok: 1'b0, value: '0};
               acc_in  = '0;
               pos_in  = '0;
               hex_in  = 1'b0;
               skip_in = 1'b1;
            end else begin
               acc_in = {acc_ff[ValueW-DigitW-1:0], hex_d.digit};
               pos_in = pos_inc;
            end
         end else if ((pos_ff == PosW'(1)) && (acc_ff == '0) && is_x) begin
            hex_in = 1'b1;
            pos_in = PosW'(2);
         end else if ((is_kilo || is_mega) && (pos_ff != '0)) begin
            result  = '{valid: 1'b1, ok: 1'b1,
                        value: is_kilo ? (acc_ff << KILO_SHIFT) : (acc_ff << MEGA_SHIFT)};
            acc_in  = '0;
            pos_in  = '0;
            skip_in = 1'b1;
         end else if (is_dec && (pos_inc < PosLimit)) begin
            acc_in = (acc_ff << 3) + (acc_ff << 1) + ValueW'(char_code - CHAR_ZERO);
            pos_in = pos_inc;
         end else begin
            // invalid character, or decimal length limit reached
            result  = '{valid: 1'b1, ok: 1'b0, value: '0};
            acc_in  = '0;
            pos_in  = '0;
            skip_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         hex_ff  <= 1'b0;
         skip_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         hex_ff  <= hex_in;
         skip_ff <= skip_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_ascii_number_parser.sv @@
// ----------------------------------------------------------------------------
// tb_ascii_number_parser
// Self-checking bench for the ASCII number parser. Feeds characters one
// transaction at a time in bursts with gaps, stalls the result side in
// shifting patterns, and compares each result with a local model of the
// parser. A short directed table runs first, then random strings: decimal
// with suffixes, hex, broken strings and noise.
// ----------------------------------------------------------------------------
module tb_ascii_number_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import anp_pkg::*;

   localparam int ScanLimit   = 11;
   localparam int RandomItems = 650;
   localparam int NumDirected = 36;
   localparam int MaxReports  = 10;

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic              ok;
   } number_type;

   typedef struct packed {
      logic [CharW-1:0]  ch;
      bit                typed;
      logic [ValueW-1:0] value;
      bit                ok;
   } stim_row_type;

   // typed rows carry their own expected result, the rest use the model
   localparam stim_row_type DirectedRows [NumDirected] = '{
      '{CHAR_NUL,              1'b1, 32'h0000_0000, 1'b1},
      '{CHAR_ZERO,             1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_X,          1'b0, 32'h0,         1'b0},
      '{CHAR_NUL,              1'b1, 32'h0000_0000, 1'b1},
      '{CHAR_LOWER_M,          1'b1, 32'h0000_0000, 1'b0},
      '{CHAR_NUL,              1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd7,      1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_K,          1'b1, 32'h0000_1C00, 1'b1},
      '{CHAR_LOWER_X,          1'b0, 32'h0,         1'b0},
      '{CHAR_NUL,              1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO,             1'b0, 32'h0,         1'b0},
      '{CHAR_LOWER_X,          1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_LOWER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_LOWER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_LOWER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_LOWER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_UPPER_F,          1'b0, 32'h0,         1'b0},
      '{CHAR_NUL,              1'b1, 32'hFFFF_FFFF, 1'b1},
      '{8'hFF,                 1'b1, 32'h0000_0000, 1'b0},
      '{CHAR_NUL,              1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd1,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd2,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd3,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd4,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd5,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd6,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd7,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd8,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd9,      1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO,             1'b0, 32'h0,         1'b0},
      '{CHAR_ZERO + 8'd1,      1'b1, 32'h0000_0000, 1'b0},
      '{CHAR_NUL,              1'b0, 32'h0,         1'b0}
   };

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [CharW-1:0]  req_tdata;   // [7:0] char_code
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [ValueW-1:0] rsp_tdata;   // [31:0] number_value
   logic              rsp_tuser;   // [0] parse_ok

   // model state
   logic [ValueW-1:0] num_acc;
   logic [PosW-1:0]   num_pos;
   bit                in_hex;
   bit                dropping;

   number_type        pending_numbers[$];
   number_type        oldest;
   logic [CharW-1:0]  text_q[$];

   int unsigned       burst_left;
   int unsigned       parsed_chars;
   int unsigned       strings_sent;
   int unsigned       ok_results;
   int unsigned       rejected_results;
   int unsigned       errors;

   ascii_number_parser #(
      .SCAN_LIMIT (ScanLimit)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("ascii_number_parser test failed");
      $finish;
   end

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= MaxReports) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // advances the model by one character; returns 1 when a number is closed
   function automatic bit parse_char(input logic [CharW-1:0] ch, output number_type res);
      bit               done;
      bit               at_nul;
      bit               hex_ok;
      logic [DigitW-1:0] nibble;
      done   = 1'b0;
      at_nul = 1'b0;
      res    = '{value: '0, ok: 1'b0};
      hex_ok = 1'b1;
      nibble = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         nibble = DigitW'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
         nibble = DigitW'(ch - CHAR_LOWER_A + 8'd10);
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
         nibble = DigitW'(ch - CHAR_UPPER_A + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end

      if (dropping) begin
         if (ch == CHAR_NUL) dropping = 1'b0;
      end else if (ch == CHAR_NUL) begin
         res    = '{value: num_acc, ok: 1'b1};
         done   = 1'b1;
         at_nul = 1'b1;
      end else if (in_hex) begin
         if (num_pos >= ScanLimit || !hex_ok) begin
            done = 1'b1;
         end else begin
            num_acc = {num_acc[ValueW-5:0], nibble};
            num_pos = num_pos + 1'b1;
         end
      end else if (num_pos == 1 && num_acc == '0 &&
                   (ch == CHAR_LOWER_X || ch == CHAR_UPPER_X)) begin
         in_hex  = 1'b1;
         num_pos = PosW'(2);
      end else if ((ch == CHAR_LOWER_K || ch == CHAR_UPPER_K) && num_pos != 0) begin
         res  = '{value: num_acc << KILO_SHIFT, ok: 1'b1};
         done = 1'b1;
      end else if ((ch == CHAR_LOWER_M || ch == CHAR_UPPER_M) && num_pos != 0) begin
         res  = '{value: num_acc << MEGA_SHIFT, ok: 1'b1};
         done = 1'b1;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         num_acc = num_acc * 32'd10 + ValueW'(ch - CHAR_ZERO);
         num_pos = num_pos + 1'b1;
         if (num_pos >= ScanLimit) done = 1'b1;
      end else begin
         done = 1'b1;
      end

      if (done) begin
         num_acc  = '0;
         num_pos  = '0;
         in_hex   = 1'b0;
         dropping = !at_nul;
      end
      return done;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_char(input logic [CharW-1:0] ch, input bit typed = 1'b0,
                            input logic [ValueW-1:0] typed_value = '0,
                            input bit typed_ok = 1'b0);
      int unsigned gap;
      number_type  res;
      bit          closes;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid = 1'b1;
      req_tdata  = ch;
      do @(posedge clock); while (!req_tready);
      parsed_chars++;
      if (ch == CHAR_NUL) strings_sent++;
      closes = parse_char(ch, res);
      if (typed) begin
         pending_numbers.push_back('{value: typed_value, ok: typed_ok});
      end else if (closes) begin
         pending_numbers.push_back(res);
      end
      burst_left--;
      @(negedge clock);
   endtask

   function automatic logic [CharW-1:0] pick_hex_digit();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) return CHAR_ZERO + CharW'(v);
      return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + CharW'(v - 10);
   endfunction

   function automatic logic [CharW-1:0] pick_dec_digit();
      return CHAR_ZERO + CharW'($urandom_range(0, 9));
   endfunction

   function automatic logic [CharW-1:0] pick_junk();
      return CharW'($urandom_range(1, 255));
   endfunction

   // builds one random string, NUL included, into text_q
   task automatic make_string();
      int unsigned kind;
      int unsigned n;
      int unsigned sel;
      text_q.delete();
      kind = $urandom_range(0, 19);
      if (kind <= 6) begin
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 10);
         repeat (n) text_q.push_back(pick_dec_digit());
         if ($urandom_range(0, 2) == 0) begin
            sel = $urandom_range(0, 3);
            case (sel)
               0:       text_q.push_back(CHAR_LOWER_K);
               1:       text_q.push_back(CHAR_UPPER_K);
               2:       text_q.push_back(CHAR_LOWER_M);
               default: text_q.push_back(CHAR_UPPER_M);
            endcase
            repeat ($urandom_range(0, 3)) text_q.push_back(pick_junk());
         end
      end else if (kind <= 12) begin
         text_q.push_back(CHAR_ZERO);
         text_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 8);
         repeat (n) text_q.push_back(pick_hex_digit());
         if ($urandom_range(0, 3) == 0) text_q.push_back(pick_junk());
      end else if (kind <= 15) begin
         repeat ($urandom_range(0, 5)) text_q.push_back(pick_dec_digit());
         text_q.push_back(pick_junk());
         repeat ($urandom_range(0, 3)) text_q.push_back(pick_junk());
      end else if (kind <= 17) begin
         repeat ($urandom_range(1, 8)) text_q.push_back(CharW'($urandom_range(0, 255)));
      end else if (kind == 19) begin
         sel = $urandom_range(0, 3);
         case (sel)
            0: text_q.push_back(CHAR_ZERO + CharW'($urandom_range(1, 9)));
            1: begin
               text_q.push_back(CHAR_ZERO);
               text_q.push_back(CHAR_ZERO);
            end
            2: ;
            default: text_q.push_back(CHAR_ZERO);
         endcase
         if (sel != 3) begin
            text_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
         end
         repeat ($urandom_range(0, 3)) text_q.push_back(pick_dec_digit());
      end
      text_q.push_back(CHAR_NUL);
   endtask

   // result side: back-pressure mode changes every so often
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned tick;
      rsp_tready = 1'b0;
      mode       = 0;
      span       = 0;
      tick       = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
         end
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = ($urandom_range(0, 3) != 0);
            2:       rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = ((tick % 7) < 3);
         endcase
         span--;
         tick++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser) ok_results++;
         else rejected_results++;
         if (pending_numbers.size() == 0) begin
            note_error($sformatf("unexpected result: value %08h ok %0b",
                                 rsp_tdata, rsp_tuser));
         end else begin
            oldest = pending_numbers.pop_front();
            if (rsp_tdata !== oldest.value) begin
               note_error($sformatf("value mismatch: expected %08h, got %08h",
                                    oldest.value, rsp_tdata));
            end
            if (rsp_tuser !== oldest.ok) begin
               note_error($sformatf("ok flag mismatch: expected %0b, got %0b",
                                    oldest.ok, rsp_tuser));
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      num_acc          = '0;
      num_pos          = '0;
      in_hex           = 1'b0;
      dropping         = 1'b0;
      burst_left       = 0;
      parsed_chars     = 0;
      strings_sent     = 0;
      ok_results       = 0;
      rejected_results = 0;
      errors           = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NumDirected; i++) begin
         send_char(DirectedRows[i].ch, DirectedRows[i].typed,
                   DirectedRows[i].value, DirectedRows[i].ok);
      end

      parsed_chars = 0;
      while (parsed_chars < RandomItems) begin
         make_string();
         foreach (text_q[j]) send_char(text_q[j]);
      end
      req_tvalid = 1'b0;

      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d strings parsed, %0d characters in the random part", strings_sent,
               parsed_chars);
      $display("%0d numbers accepted, %0d strings rejected, %0d mismatches", ok_results,
               rejected_results, errors);
      if (errors == 0) begin
         $display("ascii_number_parser test passed");
      end else begin
         $display("ascii_number_parser test failed");
      end
      $finish;
   end

endmodule
